// File: sv/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the causal link tester.
// ----------------------------------------------------------------------------
package clt_pkg;

	// Widths of the input fields on the ports
	localparam int unsigned IDX_BITS      = 10;
	localparam int unsigned IN_COORD_BITS = 16;

	// Defaults for the top-level parameters
	localparam int unsigned POINTS_DEF     = 1024;
	localparam int unsigned COORD_BITS_DEF = 16;

	// Fraction bits of the reciprocal used for the index reduction
	localparam int unsigned RECIP_SHIFT = 2 * IDX_BITS;

	// Operation codes
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_PAIR  = 1'b1;

	// Status codes
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_ORDER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE1,
		ST_REDUCE2,
		ST_DISPATCH,
		ST_RD_LATER,
		ST_CHECK,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Flags from the separation unit
	typedef struct packed {
		logic rel_a;    // earlier end vs. candidate
		logic rel_b;    // candidate vs. later end
	} sep_flags_t;

endpackage

// File: sv/causal_link_tester_top.sv
// ----------------------------------------------------------------------------
// causal_link_tester_top
// Point table in spacetime with a causal-relation and link tester.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): operation 0 stores (time_coord,
// space_coord) at slot later_index; operation 1 tests the pair
// earlier_index < later_index. Indices are taken modulo POINTS.
// Output channel (out_valid/out_ready): one transfer per input item with
// related, is_link and status (status 1: indices out of order).
// One item is worked on at a time; in_ready is high only while idle.
// A store and an out-of-order pair go straight from dispatch to finish. A
// valid pair reads both ends and, if they are related and not adjacent,
// walks the slots strictly between the two indices, stopping at the first
// point related to both ends. The walk is bound by the single read port
// of the point RAM, one stored point per cycle into the separation unit.
// The next item is taken as soon as the result sits in the output
// register, even if the receiver has not yet taken it; a stalled receiver
// holds the block only when a second result is ready.
// Reset clears the sequencer and the output valid; the point table is not
// cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module causal_link_tester_top #(
	parameter int unsigned POINTS     = clt_pkg::POINTS_DEF,
	parameter int unsigned COORD_BITS = clt_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [clt_pkg::IDX_BITS-1:0]      later_index,
	input  logic [clt_pkg::IDX_BITS-1:0]      earlier_index,
	input  logic [clt_pkg::IN_COORD_BITS-1:0] time_coord,
	input  logic [clt_pkg::IN_COORD_BITS-1:0] space_coord,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              related,
	output logic                              is_link,
	output logic                              status
);

	localparam int unsigned AW = $clog2(POINTS);
	localparam int unsigned CB = COORD_BITS;

	clt_pkg::state_t state_q;
	clt_pkg::state_t state_d;

	logic                         op_q;
	logic [clt_pkg::IDX_BITS-1:0] later_raw_q;
	logic [clt_pkg::IDX_BITS-1:0] earlier_raw_q;
	logic [CB-1:0]                time_q;
	logic [CB-1:0]                space_q;

	logic [AW-1:0] later_s2;
	logic [AW-1:0] earlier_s2;
	logic [AW-1:0] k_q;

	logic [CB-1:0] e_time_q;
	logic [CB-1:0] e_space_q;
	logic [CB-1:0] l_time_q;
	logic [CB-1:0] l_space_q;

	logic rel_q;
	logic link_q;
	logic stat_q;
	logic out_valid_q;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [2*CB-1:0] ram_rdata;
	logic [CB-1:0] rd_time;
	logic [CB-1:0] rd_space;

	logic                accept;
	logic                slot_free;
	logic                in_order;
	logic                hit;
	logic                last_k;
	logic                adjacent;
	clt_pkg::sep_flags_t flags;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign in_order  = (earlier_s2 < later_s2);
	assign hit       = flags.rel_a && flags.rel_b;
	assign last_k    = ((k_q + AW'(1)) == later_s2);
	assign adjacent  = ((earlier_s2 + AW'(1)) == later_s2);

	assign rd_time  = ram_rdata[2*CB-1 -: CB];
	assign rd_space = ram_rdata[CB-1:0];

	clt_idx_reduce #(
		.POINTS(POINTS)
	) u_red_later (
		.clk   (clk),
		.idx   (later_raw_q),
		.idx_s2(later_s2)
	);

	clt_idx_reduce #(
		.POINTS(POINTS)
	) u_red_earlier (
		.clk   (clk),
		.idx   (earlier_raw_q),
		.idx_s2(earlier_s2)
	);

	clt_ram #(
		.WIDTH(2 * CB),
		.DEPTH(POINTS)
	) u_points (
		.clk  (clk),
		.we   (ram_we),
		.waddr(later_s2),
		.wdata({time_q, space_q}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	clt_sep_unit #(
		.COORD_BITS(CB)
	) u_sep (
		.a_time (e_time_q),
		.a_space(e_space_q),
		.b_time (l_time_q),
		.b_space(l_space_q),
		.c_time (rd_time),
		.c_space(rd_space),
		.flags  (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = earlier_s2;
		case (state_q)
			clt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = clt_pkg::ST_REDUCE1;
				end
			end
			clt_pkg::ST_REDUCE1: begin
				state_d = clt_pkg::ST_REDUCE2;
			end
			clt_pkg::ST_REDUCE2: begin
				state_d = clt_pkg::ST_DISPATCH;
			end
			clt_pkg::ST_DISPATCH: begin
				if (op_q == clt_pkg::OP_STORE) begin
					ram_we  = 1'b1;
					state_d = clt_pkg::ST_FINISH;
				end else if (!in_order) begin
					state_d = clt_pkg::ST_FINISH;
				end else begin
					state_d = clt_pkg::ST_RD_LATER;
				end
			end
			clt_pkg::ST_RD_LATER: begin
				ram_raddr = later_s2;
				state_d   = clt_pkg::ST_CHECK;
			end
			clt_pkg::ST_CHECK: begin
				ram_raddr = earlier_s2 + AW'(1);
				if (!flags.rel_a || adjacent) begin
					state_d = clt_pkg::ST_FINISH;
				end else begin
					state_d = clt_pkg::ST_WALK;
				end
			end
			clt_pkg::ST_WALK: begin
				ram_raddr = k_q + AW'(1);
				if (hit || last_k) begin
					state_d = clt_pkg::ST_FINISH;
				end
			end
			clt_pkg::ST_FINISH: begin
				if (slot_free) begin
					state_d = clt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = clt_pkg::ST_IDLE;
			end
		endcase
	end

	// Item capture and walk datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= operation;
			later_raw_q   <= later_index;
			earlier_raw_q <= earlier_index;
			time_q        <= CB'(time_coord);
			space_q       <= CB'(space_coord);
		end
		case (state_q)
			clt_pkg::ST_DISPATCH: begin
				rel_q  <= 1'b0;
				link_q <= 1'b0;
				stat_q <= (op_q == clt_pkg::OP_PAIR && !in_order) ?
					clt_pkg::STAT_ORDER : clt_pkg::STAT_OK;
			end
			clt_pkg::ST_RD_LATER: begin
				e_time_q  <= rd_time;
				e_space_q <= rd_space;
			end
			clt_pkg::ST_CHECK: begin
				l_time_q  <= rd_time;
				l_space_q <= rd_space;
				rel_q     <= flags.rel_a;
				link_q    <= flags.rel_a;
				k_q       <= earlier_s2 + AW'(1);
			end
			clt_pkg::ST_WALK: begin
				// Drop the link on the first point related to both ends
				if (hit) begin
					link_q <= 1'b0;
				end
				k_q <= k_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == clt_pkg::ST_FINISH && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == clt_pkg::ST_FINISH && slot_free) begin
			related <= rel_q;
			is_link <= link_q;
			status  <= stat_q;
		end
	end

	assign out_valid = out_valid_q;

	a_rise_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == clt_pkg::ST_FINISH))
		else $error("result appeared without a finished item");

	a_link_needs_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_link) |-> related)
		else $error("link reported for an unrelated pair");

	a_order_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == clt_pkg::STAT_ORDER) |-> (!related && !is_link))
		else $error("order error with relation flags set");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clt_pkg::ST_WALK) |-> (k_q > earlier_s2 && k_q < later_s2))
		else $error("walk index outside the pair");

endmodule

// File: sv/clt_ram.sv
// ----------------------------------------------------------------------------
// clt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module clt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/clt_idx_reduce.sv
// ----------------------------------------------------------------------------
// clt_idx_reduce
// Two-stage reduction of a port index modulo POINTS (reciprocal multiply,
// then one correcting subtract; indices pass through when POINTS >= 2**IDX_BITS).
// ----------------------------------------------------------------------------
module clt_idx_reduce #(
	parameter int unsigned POINTS = clt_pkg::POINTS_DEF
) (
	input  logic                          clk,
	input  logic [clt_pkg::IDX_BITS-1:0]  idx,
	output logic [$clog2(POINTS)-1:0]     idx_s2
);

	localparam int unsigned AW = $clog2(POINTS);
	localparam int unsigned IW = clt_pkg::IDX_BITS;
	localparam int unsigned RS = clt_pkg::RECIP_SHIFT;

	generate
		if (POINTS >= (1 << IW)) begin : g_wide
			// Every port index is already a valid slot
			logic [IW-1:0] idx_s1;

			always_ff @(posedge clk) begin
				idx_s1 <= idx;
				idx_s2 <= AW'(idx_s1);
			end
		end else begin : g_narrow
			localparam logic [RS-1:0] RECIP = RS'((1 << RS) / POINTS);

			logic [IW+RS-1:0] prod;
			logic [IW-1:0]    idx_s1;
			logic [IW-1:0]    quot_s1;
			logic [RS-1:0]    back;
			logic [IW:0]      rem_raw;
			logic [IW:0]      rem_fix;

			assign prod = (IW+RS)'(idx) * (IW+RS)'(RECIP);

			// Quotient estimate is low by at most one: correct once
			assign back    = RS'(quot_s1) * RS'(POINTS);
			assign rem_raw = (IW+1)'(idx_s1) - (IW+1)'(back);
			assign rem_fix = (rem_raw >= (IW+1)'(POINTS)) ? rem_raw - (IW+1)'(POINTS) : rem_raw;

			always_ff @(posedge clk) begin
				idx_s1  <= idx;
				quot_s1 <= prod[IW+RS-1 -: IW];
				idx_s2  <= AW'(rem_fix);
			end
		end
	endgenerate

endmodule

// File: sv/clt_sep_unit.sv
// ----------------------------------------------------------------------------
// clt_sep_unit
// Separation unit: tests a candidate point against both ends of a pair,
// |dt| >= |dx| for each side.
// ----------------------------------------------------------------------------
module clt_sep_unit #(
	parameter int unsigned COORD_BITS = clt_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0] a_time,
	input  logic [COORD_BITS-1:0] a_space,
	input  logic [COORD_BITS-1:0] b_time,
	input  logic [COORD_BITS-1:0] b_space,
	input  logic [COORD_BITS-1:0] c_time,
	input  logic [COORD_BITS-1:0] c_space,
	output clt_pkg::sep_flags_t   flags
);

	logic [COORD_BITS-1:0] dt_a;
	logic [COORD_BITS-1:0] dx_a;
	logic [COORD_BITS-1:0] dt_b;
	logic [COORD_BITS-1:0] dx_b;

	assign dt_a = (a_time  >= c_time)  ? a_time  - c_time  : c_time  - a_time;
	assign dx_a = (a_space >= c_space) ? a_space - c_space : c_space - a_space;
	assign dt_b = (b_time  >= c_time)  ? b_time  - c_time  : c_time  - b_time;
	assign dx_b = (b_space >= c_space) ? b_space - c_space : c_space - b_space;

	assign flags.rel_a = (dt_a >= dx_a);
	assign flags.rel_b = (dt_b >= dx_b);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Causal link tester testbench
// Stores spacetime points and tests pairs of them on the block. Every result
// is compared with a fixed expected value or with a local model of the point
// table and the link rule. A short table of directed items runs first. Random
// runs of points, mostly sorted by time, follow, each with pair tests inside it,
// mixed with stray stores, out-of-order pairs and long pairs across the slots
// written so far. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned POINTS       = clt_pkg::POINTS_DEF;
	localparam int unsigned RANDOM_ITEMS = 580;
	localparam int unsigned STALL_LIMIT  = 20000;

	typedef struct packed {
		logic                              op;
		logic [clt_pkg::IDX_BITS-1:0]      later;
		logic [clt_pkg::IDX_BITS-1:0]      earlier;
		logic [clt_pkg::IN_COORD_BITS-1:0] tcoord;
		logic [clt_pkg::IN_COORD_BITS-1:0] scoord;
	} pt_item_t;

	typedef struct packed {
		logic related;
		logic is_link;
		logic status;
	} link_res_t;

	typedef struct {
		pt_item_t  item;
		bit        fixed;
		link_res_t res;
	} vector_t;

	localparam link_res_t RES_DONE  = '{1'b0, 1'b0, clt_pkg::STAT_OK};
	localparam link_res_t RES_ORDER = '{1'b0, 1'b0, clt_pkg::STAT_ORDER};
	localparam link_res_t RES_LINK  = '{1'b1, 1'b1, clt_pkg::STAT_OK};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic                              operation = clt_pkg::OP_STORE;
	logic [clt_pkg::IDX_BITS-1:0]      later_index = '0;
	logic [clt_pkg::IDX_BITS-1:0]      earlier_index = '0;
	logic [clt_pkg::IN_COORD_BITS-1:0] time_coord = '0;
	logic [clt_pkg::IN_COORD_BITS-1:0] space_coord = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic                              related;
	logic                              is_link;
	logic                              status;

	logic [clt_pkg::IN_COORD_BITS-1:0] pt_time [POINTS];
	logic [clt_pkg::IN_COORD_BITS-1:0] pt_space [POINTS];
	bit                                slot_written [POINTS];

	link_res_t   expected_q [$];
	vector_t     vector_q [$];
	int unsigned fail_count = 0;
	int unsigned items_issued = 0;
	int unsigned idle_cycles = 0;
	bit          no_idle = 1'b0;

	causal_link_tester_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.later_index  (later_index),
		.earlier_index(earlier_index),
		.time_coord   (time_coord),
		.space_coord  (space_coord),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.related      (related),
		.is_link      (is_link),
		.status       (status)
	);

	always #1 clk = ~clk;

	// |dt| >= |dx| decides dt^2 - dx^2 >= 0 exactly
	function automatic bit is_causal(int unsigned a, int unsigned b);
		logic [clt_pkg::IN_COORD_BITS-1:0] dt;
		logic [clt_pkg::IN_COORD_BITS-1:0] dx;
		dt = (pt_time[a] >= pt_time[b]) ? pt_time[a] - pt_time[b]
			: pt_time[b] - pt_time[a];
		dx = (pt_space[a] >= pt_space[b]) ? pt_space[a] - pt_space[b]
			: pt_space[b] - pt_space[a];
		return dt >= dx;
	endfunction

	// Apply one item to the local point table and return its outcome
	function automatic link_res_t link_outcome(pt_item_t it);
		link_res_t   r;
		int unsigned k;
		r = '0;
		if (it.op == clt_pkg::OP_STORE) begin
			pt_time[it.later]      = it.tcoord;
			pt_space[it.later]     = it.scoord;
			slot_written[it.later] = 1'b1;
			r.status = clt_pkg::STAT_OK;
			return r;
		end
		if (it.earlier >= it.later) begin
			r.status = clt_pkg::STAT_ORDER;
			return r;
		end
		r.status  = clt_pkg::STAT_OK;
		r.related = is_causal(it.earlier, it.later);
		r.is_link = r.related;
		if (r.related) begin
			for (k = it.earlier + 1; k < it.later; k++) begin
				if (is_causal(it.earlier, k) && is_causal(k, it.later))
					r.is_link = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic pt_item_t mk_item(logic op, int unsigned later, int unsigned earlier,
			int unsigned tc, int unsigned sc);
		pt_item_t it;
		it.op      = op;
		it.later   = later[clt_pkg::IDX_BITS-1:0];
		it.earlier = earlier[clt_pkg::IDX_BITS-1:0];
		it.tcoord  = tc[clt_pkg::IN_COORD_BITS-1:0];
		it.scoord  = sc[clt_pkg::IN_COORD_BITS-1:0];
		return it;
	endfunction

	function automatic void add_row(pt_item_t it, bit fixed, link_res_t res);
		vector_t v;
		v.item  = it;
		v.fixed = fixed;
		v.res   = res;
		vector_q.insert(vector_q.size(), v);
	endfunction

	// Last slot of the written run that starts at first
	function automatic int unsigned run_end(int unsigned first);
		int unsigned last;
		last = first;
		while (last < POINTS - 1 && slot_written[last + 1])
			last++;
		return last;
	endfunction

	// Present one item, hold it until the transfer, then queue its outcome
	task automatic issue(pt_item_t it, bit fixed, link_res_t fixed_res);
		link_res_t pred;
		if (!no_idle && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= it.op;
		later_index   <= it.later;
		earlier_index <= it.earlier;
		time_coord    <= it.tcoord;
		space_coord   <= it.scoord;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = link_outcome(it);
		expected_q.insert(expected_q.size(), fixed ? fixed_res : pred);
		items_issued++;
	endtask

	task automatic issue_random(pt_item_t it);
		issue(it, 1'b0, '0);
	endtask

	// Output side: random stalls, compare each transfer with the oldest outcome
	always @(posedge clk) begin
		link_res_t got;
		link_res_t want;
		out_ready <= no_idle || ($urandom_range(0, 99) >= 11);
		if (arst_n && out_valid && out_ready) begin
			got.related = related;
			got.is_link = is_link;
			got.status  = status;
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result with nothing expected: rel=%b link=%b status=%b",
						$realtime, got.related, got.is_link, got.status);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: expected rel=%b link=%b st=%b, got rel=%b link=%b st=%b",
							$realtime, want.related, want.is_link, want.status,
							got.related, got.is_link, got.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned base;
		int unsigned len;
		int unsigned e;
		int unsigned l;
		int unsigned t0;
		int unsigned c;
		int unsigned k;
		int unsigned mode;
		int unsigned tries;
		bit          spread;
		bit          found;

		// slot 0 and 1023 hold the coordinate extremes
		add_row(mk_item(clt_pkg::OP_STORE, 0, 1023, 16'h0000, 16'h0000), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_STORE, 1023, 0, 16'hFFFF, 16'hFFFF), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_PAIR, 0, 0, 16'hFFFF, 16'h0000), 1, RES_ORDER);
		add_row(mk_item(clt_pkg::OP_PAIR, 0, 1023, 16'h0000, 16'hFFFF), 1, RES_ORDER);
		add_row(mk_item(clt_pkg::OP_PAIR, 512, 512, 16'hA5A5, 16'h5A5A), 1, RES_ORDER);
		add_row(mk_item(clt_pkg::OP_STORE, 1, 682, 16'h0010, 16'h0008), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_PAIR, 1, 0, 16'h0000, 16'h0000), 1, RES_LINK);
		add_row(mk_item(clt_pkg::OP_STORE, 2, 341, 16'h0020, 16'h0030), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_PAIR, 2, 0, 16'h0000, 16'h0000), 0, '0);
		add_row(mk_item(clt_pkg::OP_STORE, 1022, 1023, 16'hFFF0, 16'hFFF0), 1, RES_DONE);
		// lightlike pair at the top of the table
		add_row(mk_item(clt_pkg::OP_PAIR, 1023, 1022, 16'h0000, 16'h0000), 1, RES_LINK);
		add_row(mk_item(clt_pkg::OP_STORE, 2, 0, 16'h0020, 16'h0010), 1, RES_DONE);
		// slot 1 sits inside the light cone of both ends
		add_row(mk_item(clt_pkg::OP_PAIR, 2, 0, 16'h1234, 16'h4321), 0, '0);
		add_row(mk_item(clt_pkg::OP_STORE, 3, 0, 16'h0021, 16'hFFFF), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_PAIR, 3, 1, 16'h0000, 16'h0000), 0, '0);
		add_row(mk_item(clt_pkg::OP_PAIR, 3, 0, 16'h0000, 16'h0000), 0, '0);
		add_row(mk_item(clt_pkg::OP_STORE, 4, 0, 16'h8000, 16'h0000), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_STORE, 5, 0, 16'hFFFF, 16'h8000), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_PAIR, 5, 4, 16'h0000, 16'h0000), 0, '0);
		// unsorted: slot 5 now earlier in time than slot 4
		add_row(mk_item(clt_pkg::OP_STORE, 5, 0, 16'h0000, 16'h0000), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_PAIR, 5, 4, 16'h0000, 16'h0000), 0, '0);
		add_row(mk_item(clt_pkg::OP_PAIR, 5, 0, 16'h0000, 16'h0000), 0, '0);
		add_row(mk_item(clt_pkg::OP_STORE, 1021, 682, 16'h0000, 16'hFFFF), 1, RES_DONE);
		add_row(mk_item(clt_pkg::OP_PAIR, 1023, 1021, 16'h0000, 16'h0000), 0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vector_q[i])
			issue(vector_q[i].item, vector_q[i].fixed, vector_q[i].res);

		items_issued = 0;
		while (items_issued < RANDOM_ITEMS) begin
			no_idle = (items_issued >= 250 && items_issued < 350);
			mode = $urandom_range(0, 99);
			if (mode < 55) begin
				// run of points, sorted by time unless spread, then pair tests inside it
				len    = $urandom_range(2, 12);
				base   = $urandom_range(0, POINTS - len);
				spread = ($urandom_range(0, 4) == 0);
				t0     = $urandom_range(0, 65535 - len * 512);
				c      = $urandom_range(16'h0400, 16'hFBFF);
				for (k = 0; k < len; k++) begin
					if (spread)
						issue_random(mk_item(clt_pkg::OP_STORE, base + k,
							$urandom_range(0, 1023),
							$urandom_range(0, 65535), $urandom_range(0, 65535)));
					else begin
						t0 = t0 + $urandom_range(0, 511);
						issue_random(mk_item(clt_pkg::OP_STORE, base + k,
							$urandom_range(0, 1023),
							t0, c - 16'h0300 + $urandom_range(0, 16'h0600)));
					end
				end
				repeat ($urandom_range(1, 4)) begin
					e = base + $urandom_range(0, len - 2);
					l = $urandom_range(e + 1, base + len - 1);
					issue_random(mk_item(clt_pkg::OP_PAIR, l, e, $urandom_range(0, 65535),
						$urandom_range(0, 65535)));
				end
			end else if (mode < 80) begin
				// pair across a run of written slots, or an out-of-order pair if none is found
				found = 1'b0;
				for (tries = 0; tries < 8 && !found; tries++) begin
					e = $urandom_range(0, POINTS - 2);
					found = slot_written[e] && slot_written[e + 1];
				end
				if (found) begin
					l = run_end(e);
					if ($urandom_range(0, 19) != 0 && l > e + 40)
						l = e + $urandom_range(1, 40);
				end else begin
					l = $urandom_range(0, POINTS - 1);
					e = $urandom_range(l, POINTS - 1);
				end
				issue_random(mk_item(clt_pkg::OP_PAIR, l, e, $urandom_range(0, 65535),
					$urandom_range(0, 65535)));
			end else if (mode < 90) begin
				issue_random(mk_item(clt_pkg::OP_STORE, $urandom_range(0, POINTS - 1),
					$urandom_range(0, 1023), $urandom_range(0, 65535),
					$urandom_range(0, 65535)));
			end else begin
				// indices out of order: never read the table
				l = $urandom_range(0, POINTS - 1);
				e = $urandom_range(l, POINTS - 1);
				issue_random(mk_item(clt_pkg::OP_PAIR, l, e, $urandom_range(0, 65535),
					$urandom_range(0, 65535)));
			end
		end

		in_valid <= 1'b0;
		no_idle = 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
